>>> rtl/core/assert_macros.svh
// assertion macros used by scrolling_status_line
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

>>> rtl/core/ssl_pkg.sv
// shared types and constants of the scrolling status line
package ssl_pkg;

   localparam int BUFFER_DEPTH_DEF  = 32;
   localparam int DISPLAY_WIDTH_DEF = 16;

   localparam int DWELL_W    = 16;
   localparam int CHAR_W     = 8;
   localparam int COLUMN_W   = 4;
   localparam int OFFSET_W   = 5;
   localparam int CMD_W      = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_IDX_W  = 2;

   localparam logic [DWELL_W-1:0] END_DWELL_RESET  = 16'd2000;
   localparam logic [DWELL_W-1:0] STEP_DWELL_RESET = 16'd500;
   localparam logic [CHAR_W-1:0]  SPACE_CHAR       = 8'h20;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_FINISH = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_END_DWELL  = 2'd0,
      CSR_STEP_DWELL = 2'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_RENDER = 2'b10
   } state_type;

   typedef struct packed {
      logic                last;
      logic [OFFSET_W-1:0] offset;
      logic [CHAR_W-1:0]   glyph;
      logic [COLUMN_W-1:0] column;
   } rsp_item_type;

endpackage

>>> rtl/core/scrolling_status_line.sv
// scrolling status line: marquee text store, dwell timer and render sequencer
// a finish or an expiring tick's first column passes the state, read and queue registers
// a render sends DISPLAY_WIDTH columns, one a cycle unless rsp_tready stalls them, set
// by the single read port of the character memory; other requests send nothing
// a new request is taken once the last column read of a render has been issued
// reset clears length, scroll position and timer, loads the dwell defaults; memory is kept
`include "assert_macros.svh"

module scrolling_status_line #(
   parameter int BUFFER_DEPTH  = ssl_pkg::BUFFER_DEPTH_DEF,
   parameter int DISPLAY_WIDTH = ssl_pkg::DISPLAY_WIDTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ssl_pkg::REQ_DATA_W-1:0]   req_tdata,   // [7:0] char_in
   input  logic [ssl_pkg::CMD_W-1:0]        req_tuser,   // [1:0] command
   // rendered column channel
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ssl_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [3:0] column, [11:4] glyph,
                                                         // [16:12] offset, [23:17] zero
   output logic                             rsp_tlast,   // last
   // register write port
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ssl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssl_pkg::DWELL_W-1:0]      csr_data
);
   import ssl_pkg::*;

   // text length must hold BUFFER_DEPTH itself
   localparam int LW  = $clog2(BUFFER_DEPTH + 1);
   localparam int AW  = $clog2(BUFFER_DEPTH);
   localparam int CW  = (DISPLAY_WIDTH > 1) ? $clog2(DISPLAY_WIDTH) : 1;
   localparam int CXW = (CW > COLUMN_W) ? CW : COLUMN_W;
   // render index: offset plus column
   localparam int IW  = $clog2(BUFFER_DEPTH + DISPLAY_WIDTH);
   localparam logic [CW-1:0] LAST_COL = CW'(DISPLAY_WIDTH - 1);
   localparam logic [COLUMN_W-1:0] LAST_COLUMN = COLUMN_W'(DISPLAY_WIDTH - 1);

   // character memory, one write and one registered read port
   logic [CHAR_W-1:0] char_mem [BUFFER_DEPTH];

   // control and dwell registers
   state_type             state_ff, state_in;
   logic [LW-1:0]         text_len_ff, text_len_in;
   logic [LW-1:0]         scroll_off_ff, scroll_off_in;
   logic                  timer_armed_ff, timer_armed_in;
   logic [DWELL_W-1:0]    timer_left_ff, timer_left_in;
   logic [DWELL_W-1:0]    end_dwell_ff, step_dwell_ff;
   logic [CW-1:0]         col_ff, col_in;

   // read stage
   logic                  inflight_ff;
   logic [CHAR_W-1:0]     rd_data_ff;
   logic                  rd_inrange_ff;
   logic [CW-1:0]         rd_col_ff;
   logic                  rd_last_ff;
   logic [OFFSET_W-1:0]   rd_off_ff;

   // two-entry output queue
   logic [1:0]            count_ff, count_in;
   rsp_item_type          q0_ff, q1_ff;

   logic                  req_fire, rsp_pop, issue, wr_en, push;
   cmd_type               cmd;
   logic [CHAR_W-1:0]     char_in;
   logic [LW-1:0]         top;
   logic                  long_text;
   logic [LW-1:0]         adv_off;
   logic [IW-1:0]         rd_idx;
   logic [2:0]            occupancy;
   rsp_item_type          new_item;
   logic [CXW-1:0]        col_x;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign char_in    = req_tdata[CHAR_W-1:0];
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   // scroll limit; only meaningful when the text is longer than the display
   assign long_text = (int'(text_len_ff) > DISPLAY_WIDTH);
   assign top       = text_len_ff - LW'(DISPLAY_WIDTH);

   // position after an expiry: advance, wrap after the last one, or stay for short text
   always_comb begin
      adv_off = scroll_off_ff;
      if (long_text) begin
         if (scroll_off_ff >= top) begin
            adv_off = '0;
         end else begin
            adv_off = scroll_off_ff + LW'(1);
         end
      end
   end

   assign wr_en = req_fire && (cmd == CMD_APPEND) && (char_in != '0)
                  && (int'(text_len_ff) < BUFFER_DEPTH);

   // request handling and render sequencing
   always_comb begin
      state_in       = state_ff;
      text_len_in    = text_len_ff;
      scroll_off_in  = scroll_off_ff;
      timer_armed_in = timer_armed_ff;
      timer_left_in  = timer_left_ff;
      col_in         = col_ff;
      if (req_fire) begin
         unique case (cmd)
            CMD_CLEAR: begin
               text_len_in   = '0;
               scroll_off_in = '0;
            end
            CMD_APPEND: begin
               if (wr_en) begin
                  text_len_in = text_len_ff + LW'(1);
               end
            end
            CMD_FINISH: begin
               // view back at the start, so an armed timer always takes the end dwell
               scroll_off_in  = '0;
               timer_armed_in = long_text;
               if (long_text) begin
                  timer_left_in = end_dwell_ff;
               end
               col_in   = '0;
               state_in = ST_RENDER;
            end
            CMD_TICK: begin
               if (timer_armed_ff) begin
                  if (timer_left_ff > DWELL_W'(1)) begin
                     timer_left_in = timer_left_ff - DWELL_W'(1);
                  end else begin
                     // expiry: move the view, re-arm from the new position, render
                     scroll_off_in  = adv_off;
                     timer_armed_in = long_text;
                     if (long_text) begin
                        timer_left_in = ((adv_off == '0) || (adv_off >= top))
                                        ? end_dwell_ff : step_dwell_ff;
                     end
                     col_in   = '0;
                     state_in = ST_RENDER;
                  end
               end
            end
            default: ;
         endcase
      end else if (issue) begin
         col_in = col_ff + CW'(1);
         if (col_ff == LAST_COL) begin
            state_in = ST_IDLE;
         end
      end
   end

   // a read may go out while the queue plus the read in flight stays within two
   assign occupancy = {1'b0, count_ff} + {2'b00, inflight_ff} - {2'b00, rsp_pop};
   assign issue     = (state_ff == ST_RENDER) && (occupancy < 3'd2);
   assign rd_idx    = IW'(scroll_off_ff) + IW'(col_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         char_mem[text_len_ff[AW-1:0]] <= char_in;
      end
      if (issue) begin
         rd_data_ff    <= char_mem[rd_idx[AW-1:0]];
         rd_inrange_ff <= (rd_idx < IW'(text_len_ff));
         rd_col_ff     <= col_ff;
         rd_last_ff    <= (col_ff == LAST_COL);
         rd_off_ff     <= scroll_off_ff[OFFSET_W-1:0];
      end
   end

   // beyond the end of the text the column shows a space
   assign push  = inflight_ff;
   assign col_x = CXW'(rd_col_ff);
   always_comb begin
      new_item.column = col_x[COLUMN_W-1:0];
      new_item.glyph  = rd_inrange_ff ? rd_data_ff : SPACE_CHAR;
      new_item.offset = rd_off_ff;
      new_item.last   = rd_last_ff;
   end

   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, rsp_pop};
   end

   always_ff @(posedge clock) begin
      if (push && ((count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_pop))) begin
         q0_ff <= new_item;
      end else if (rsp_pop && (count_ff == 2'd2)) begin
         q0_ff <= q1_ff;
      end
      if (push && (((count_ff == 2'd1) && !rsp_pop) || ((count_ff == 2'd2) && rsp_pop))) begin
         q1_ff <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         text_len_ff    <= '0;
         scroll_off_ff  <= '0;
         timer_armed_ff <= 1'b0;
         timer_left_ff  <= '0;
         col_ff         <= '0;
         inflight_ff    <= 1'b0;
         count_ff       <= '0;
         end_dwell_ff   <= END_DWELL_RESET;
         step_dwell_ff  <= STEP_DWELL_RESET;
      end else begin
         state_ff       <= state_in;
         text_len_ff    <= text_len_in;
         scroll_off_ff  <= scroll_off_in;
         timer_armed_ff <= timer_armed_in;
         timer_left_ff  <= timer_left_in;
         col_ff         <= col_in;
         inflight_ff    <= issue;
         count_ff       <= count_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_END_DWELL:  end_dwell_ff  <= csr_data;
               CSR_STEP_DWELL: step_dwell_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_tdata  = RSP_DATA_W'({q0_ff.offset, q0_ff.glyph, q0_ff.column});
   assign rsp_tlast  = q0_ff.last;

   // queue never holds more than two columns
   `ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff != 2'd3, "output queue overflow")
   // a full queue only takes a column when one leaves the same cycle
   `ASSERT_IMPLY(a_push_room, clock, reset, push && (count_ff == 2'd2), rsp_pop, "push into full queue")
   // finish always starts a render
   `ASSERT_NEXT(a_finish_render, clock, reset, req_fire && (cmd == CMD_FINISH), state_ff == ST_RENDER, "finish without render")
   // last marks only the final display column
   `ASSERT_IMPLY(a_last_column, clock, reset, rsp_tvalid && rsp_tlast, q0_ff.column == LAST_COLUMN, "last on wrong column")

endmodule
